@@ sv/assert_macros.svh @@
// Assertion macros for the checker file of the frequency shifter.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define SSB_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion checked on every edge, reset included.
`define SSB_ASSERT_ALL(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/ssb_pkg.sv @@
// Package for the SSB frequency shifter: widths, allpass coefficients, sine table builder.
// No dependencies; used by scoped names from every RTL file.
package ssb_pkg;

   localparam int SAMPLE_WIDTH = 24;
   localparam int STATE_WIDTH  = SAMPLE_WIDTH + 2;
   localparam int DIFF_WIDTH   = STATE_WIDTH + 1;
   localparam int SECTIONS     = 4;
   localparam int SEC_BITS     = $clog2(SECTIONS);
   localparam int COEF_WIDTH   = 18;
   localparam int COEF_FRAC    = 18;
   localparam int TRIG_FRAC    = 23;
   localparam int TRIG_WIDTH   = TRIG_FRAC + 2;
   localparam int SINE_DEPTH   = 1024;
   localparam int SINE_ABITS   = $clog2(SINE_DEPTH + 1);
   localparam int PHASE_WIDTH  = 32;
   localparam int PHASE_IDX    = $clog2(4 * SINE_DEPTH);
   localparam int MUL_A        = DIFF_WIDTH;
   localparam int MUL_B        = TRIG_WIDTH;
   localparam int PROD_WIDTH   = MUL_A + MUL_B;
   localparam int CSR_AW       = 3;
   localparam int CSR_DW       = 32;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic signed [STATE_WIDTH-1:0]  state_type;
   typedef logic [COEF_WIDTH-1:0]          coef_type;
   typedef logic [TRIG_FRAC:0]             sine_type;
   typedef sine_type sine_table_type [SINE_DEPTH+1];

   // Register indexes of the configuration port.
   typedef enum logic [CSR_AW-3:0] {
      REG_PHASE_STEP = 1'b0
   } reg_index_type;

   localparam coef_type COEF_REAL [SECTIONS] = '{18'd181704, 18'd245384, 18'd259058, 18'd261816};
   localparam coef_type COEF_QUAD [SECTIONS] = '{18'd105432, 18'd224440, 18'd254880, 18'd260909};

   // Quarter-wave sine in Q1.23 from a ten-term Taylor series in Q30; last entry is one.
   function automatic sine_table_type build_sine_table();
      sine_table_type t;
      logic [63:0] th, th2, term, sum;
      for (int k = 0; k < SINE_DEPTH; k++) begin
         th   = (64'(k) * HALF_PI_Q30) / 64'(SINE_DEPTH);
         th2  = (th * th) >> 30;
         term = th;
         sum  = th;
         for (int n = 1; n < 10; n++) begin
            term = (term * th2) >> 30;
            term = term / 64'((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         t[k] = sine_type'((sum + 64'd64) >> 7);
      end
      t[SINE_DEPTH] = sine_type'(64'd1 << TRIG_FRAC);
      return t;
   endfunction

endpackage

@@ sv/ssb_req_if.sv @@
// Input channel of the frequency shifter: valid/ready handshake plus one sample.
// Depends on ssb_pkg.
interface ssb_req_if;
   logic                valid;
   logic                ready;
   ssb_pkg::sample_type sample_in;
   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

@@ sv/ssb_rsp_if.sv @@
// Result channel of the frequency shifter: valid/ready handshake plus one sample.
// Depends on ssb_pkg.
interface ssb_rsp_if;
   logic                valid;
   logic                ready;
   ssb_pkg::sample_type sample_out;
   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

@@ sv/ssb_frequency_shifter.sv @@
// Top level of the SSB frequency shifter: sequencer, allpass state, phase oscillator, CSR.
// Depends on ssb_pkg, ssb_req_if, ssb_rsp_if, ssb_serial_mul, ssb_sine_rom.
//
//   channel   direction  handshake            payload
//   req_chan  in         valid/ready          sample_in  (24b signed Q1.23)
//   rsp_chan  out        valid/ready          sample_out (24b signed Q1.23)
//   csr_*     in         APB write/read       phase_step (32b signed, addr 0)
//
// Each item is paced by the bit-serial multiplier, which computes ten products, one
// multiplier bit per cycle: four sections in each of two chains, plus two for the output.
// Reset is synchronous: it clears the allpass state, phase and phase_step.
// A finished item waits in the output register; the next item is accepted at once,
// and only the final write back stalls if the previous result is still untaken.
module ssb_frequency_shifter (
   input  logic                           clock,
   input  logic                           reset,
   ssb_req_if.sink                        req_chan,
   ssb_rsp_if.source                      rsp_chan,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [ssb_pkg::CSR_AW-1:0]     csr_paddr,
   input  logic [ssb_pkg::CSR_DW-1:0]     csr_pwdata,
   output logic [ssb_pkg::CSR_DW-1:0]     csr_prdata,
   output logic                           csr_pready
);
   localparam int SW = ssb_pkg::STATE_WIDTH;
   localparam int RW = SW + 2;                       // rounded section sum
   localparam int OW = ssb_pkg::PROD_WIDTH + 1;      // output difference
   localparam int OS = OW - ssb_pkg::TRIG_FRAC;      // after output shift

   typedef enum logic [3:0] {
      S_IDLE, S_SEC_START, S_SEC_WAIT, S_SEC_UPD, S_TRIG_SIN, S_TRIG_COS,
      S_TRIG_CAP, S_MUL_RE, S_WAIT_RE, S_MUL_IM, S_WAIT_IM, S_OUT
   } fsm_type;

   fsm_type                                 state_ff;
   ssb_pkg::state_type                      last_in_ff  [2][ssb_pkg::SECTIONS];
   ssb_pkg::state_type                      last_out_ff [2][ssb_pkg::SECTIONS];
   ssb_pkg::state_type                      x_ff, v_ff, re_ff, im_ff;
   logic                                    chain_ff;
   logic [ssb_pkg::SEC_BITS-1:0]            sec_ff;
   logic [ssb_pkg::PHASE_WIDTH-1:0]         phase_ff, step_ff;
   logic signed [ssb_pkg::MUL_B-1:0]        sin_ff, cos_ff;
   logic signed [ssb_pkg::PROD_WIDTH-1:0]   prod_re_ff;
   logic                                    neg_ff;
   logic                                    rsp_valid_ff;
   ssb_pkg::sample_type                     rsp_data_ff;

   logic                                    mul_start, mul_done;
   logic signed [ssb_pkg::MUL_A-1:0]        mul_a;
   logic signed [ssb_pkg::MUL_B-1:0]        mul_b;
   logic signed [ssb_pkg::PROD_WIDTH-1:0]   prod;
   ssb_pkg::state_type                      lin_sel, lout_sel, y_sat;
   logic signed [ssb_pkg::DIFF_WIDTH-1:0]   diff;
   ssb_pkg::coef_type                       coef_sel;
   logic signed [ssb_pkg::PROD_WIDTH-1:0]   prod_rnd;
   logic signed [RW-1:0]                    y_sum;
   logic signed [OW-1:0]                    out_acc;
   logic signed [OS-1:0]                    out_shift;
   ssb_pkg::sample_type                     out_sat;
   logic [ssb_pkg::PHASE_IDX-1:0]           phase_idx, trig_idx;
   logic [ssb_pkg::SINE_ABITS-1:0]          rom_addr;
   ssb_pkg::sine_type                       rom_data;
   logic signed [ssb_pkg::MUL_B-1:0]        trig_val;
   logic                                    csr_write;

   ssb_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (mul_a),
      .mplier  (mul_b),
      .done    (mul_done),
      .product (prod)
   );

   ssb_sine_rom u_rom (
      .clock (clock),
      .addr  (rom_addr),
      .data  (rom_data)
   );

   // Section arithmetic: y = round(c*(v - y1)) + x1, saturate to the state width.
   always_comb begin
      lin_sel  = last_in_ff[chain_ff][sec_ff];
      lout_sel = last_out_ff[chain_ff][sec_ff];
      coef_sel = chain_ff ? ssb_pkg::COEF_QUAD[sec_ff] : ssb_pkg::COEF_REAL[sec_ff];
      diff     = {v_ff[SW-1], v_ff} - {lout_sel[SW-1], lout_sel};
      prod_rnd = (prod + ssb_pkg::PROD_WIDTH'(64'd1 << (ssb_pkg::COEF_FRAC - 1)))
                 >>> ssb_pkg::COEF_FRAC;
      y_sum    = RW'(prod_rnd) + {{2{lin_sel[SW-1]}}, lin_sel};
      if (y_sum[RW-1:SW-1] == '0 || y_sum[RW-1:SW-1] == '1) begin
         y_sat = y_sum[SW-1:0];
      end else if (y_sum[RW-1]) begin
         y_sat = {1'b1, {(SW-1){1'b0}}};
      end else begin
         y_sat = {1'b0, {(SW-1){1'b1}}};
      end
   end

   // Output: re*cos - im*sin, round half up by 2^-23, saturate to the sample width.
   always_comb begin
      out_acc   = {prod_re_ff[ssb_pkg::PROD_WIDTH-1], prod_re_ff}
                - {prod[ssb_pkg::PROD_WIDTH-1], prod}
                + OW'(64'd1 << (ssb_pkg::TRIG_FRAC - 1));
      out_shift = OS'(out_acc >>> ssb_pkg::TRIG_FRAC);
      if (out_shift[OS-1:ssb_pkg::SAMPLE_WIDTH-1] == '0
          || out_shift[OS-1:ssb_pkg::SAMPLE_WIDTH-1] == '1) begin
         out_sat = out_shift[ssb_pkg::SAMPLE_WIDTH-1:0];
      end else if (out_shift[OS-1]) begin
         out_sat = {1'b1, {(ssb_pkg::SAMPLE_WIDTH-1){1'b0}}};
      end else begin
         out_sat = {1'b0, {(ssb_pkg::SAMPLE_WIDTH-1){1'b1}}};
      end
   end

   // Table lookup: sine on the first trig cycle, cosine (index plus one quarter) on the next.
   always_comb begin
      phase_idx = phase_ff[ssb_pkg::PHASE_WIDTH-1 -: ssb_pkg::PHASE_IDX];
      trig_idx  = (state_ff == S_TRIG_SIN) ? phase_idx
                : phase_idx + ssb_pkg::PHASE_IDX'(ssb_pkg::SINE_DEPTH);
      if (trig_idx[ssb_pkg::PHASE_IDX-2]) begin
         // falling quarter: mirror the offset
         rom_addr = ssb_pkg::SINE_ABITS'(ssb_pkg::SINE_DEPTH)
                  - {1'b0, trig_idx[ssb_pkg::PHASE_IDX-3:0]};
      end else begin
         rom_addr = {1'b0, trig_idx[ssb_pkg::PHASE_IDX-3:0]};
      end
      trig_val = neg_ff ? -{1'b0, rom_data} : {1'b0, rom_data};
   end

   // Multiplier operand select per sequencer step.
   always_comb begin
      mul_start = 1'b0;
      mul_a     = diff;
      mul_b     = ssb_pkg::MUL_B'(coef_sel);
      case (state_ff)
         S_SEC_START: begin
            mul_start = 1'b1;
         end
         S_MUL_RE: begin
            mul_start = 1'b1;
            mul_a     = {re_ff[SW-1], re_ff};
            mul_b     = cos_ff;
         end
         S_MUL_IM: begin
            mul_start = 1'b1;
            mul_a     = {im_ff[SW-1], im_ff};
            mul_b     = sin_ff;
         end
         default: begin
            mul_start = 1'b0;
         end
      endcase
   end

   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[ssb_pkg::CSR_AW-1:2] == ssb_pkg::REG_PHASE_STEP) ? step_ff : '0;

   assign req_chan.ready      = (state_ff == S_IDLE);
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.sample_out = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= '0;
         step_ff      <= '0;
         chain_ff     <= 1'b0;
         sec_ff       <= '0;
         for (int c = 0; c < 2; c++) begin
            for (int s = 0; s < ssb_pkg::SECTIONS; s++) begin
               last_in_ff[c][s]  <= '0;
               last_out_ff[c][s] <= '0;
            end
         end
      end else begin
         if (csr_write && csr_paddr[ssb_pkg::CSR_AW-1:2] == ssb_pkg::REG_PHASE_STEP) begin
            step_ff <= csr_pwdata;
         end
         // drop the taken item, unless the write back below replaces it
         if (rsp_valid_ff && rsp_chan.ready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         neg_ff <= trig_idx[ssb_pkg::PHASE_IDX-1];
         case (state_ff)
            S_IDLE: begin
               if (req_chan.valid) begin
                  x_ff     <= {{2{req_chan.sample_in[ssb_pkg::SAMPLE_WIDTH-1]}},
                               req_chan.sample_in};
                  v_ff     <= {{2{req_chan.sample_in[ssb_pkg::SAMPLE_WIDTH-1]}},
                               req_chan.sample_in};
                  chain_ff <= 1'b0;
                  sec_ff   <= '0;
                  state_ff <= S_SEC_START;
               end
            end
            S_SEC_START: begin
               state_ff <= S_SEC_WAIT;
            end
            S_SEC_WAIT: begin
               if (mul_done) begin
                  state_ff <= S_SEC_UPD;
               end
            end
            S_SEC_UPD: begin
               // hold the product; update section state and advance
               last_in_ff[chain_ff][sec_ff]  <= v_ff;
               last_out_ff[chain_ff][sec_ff] <= y_sat;
               sec_ff <= sec_ff + 1'b1;
               if (sec_ff == ssb_pkg::SEC_BITS'(ssb_pkg::SECTIONS - 1)) begin
                  if (!chain_ff) begin
                     re_ff    <= y_sat;
                     v_ff     <= x_ff;
                     chain_ff <= 1'b1;
                     state_ff <= S_SEC_START;
                  end else begin
                     im_ff    <= y_sat;
                     state_ff <= S_TRIG_SIN;
                  end
               end else begin
                  v_ff     <= y_sat;
                  state_ff <= S_SEC_START;
               end
            end
            S_TRIG_SIN: begin
               state_ff <= S_TRIG_COS;
            end
            S_TRIG_COS: begin
               sin_ff   <= trig_val;
               state_ff <= S_TRIG_CAP;
            end
            S_TRIG_CAP: begin
               cos_ff   <= trig_val;
               state_ff <= S_MUL_RE;
            end
            S_MUL_RE: begin
               state_ff <= S_WAIT_RE;
            end
            S_WAIT_RE: begin
               if (mul_done) begin
                  prod_re_ff <= prod;
                  state_ff   <= S_MUL_IM;
               end
            end
            S_MUL_IM: begin
               state_ff <= S_WAIT_IM;
            end
            S_WAIT_IM: begin
               if (mul_done) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               // hold the final product until the output register frees
               if (!rsp_valid_ff || rsp_chan.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= out_sat;
                  phase_ff     <= phase_ff + step_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end
endmodule

@@ sv/ssb_serial_mul.sv @@
// Bit-serial signed multiplier: one multiplier bit per cycle, shift-add into a shift register.
// Depends on ssb_pkg.
module ssb_serial_mul (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [ssb_pkg::MUL_A-1:0]      mcand,
   input  logic signed [ssb_pkg::MUL_B-1:0]      mplier,
   output logic                                  done,
   output logic signed [ssb_pkg::PROD_WIDTH-1:0] product
);
   localparam int CNT_BITS = $clog2(ssb_pkg::MUL_B);

   logic signed [ssb_pkg::MUL_A:0]   hi_ff, addend, sum;
   logic [ssb_pkg::MUL_B-1:0]        lo_ff;
   logic signed [ssb_pkg::MUL_A-1:0] a_ff;
   logic [CNT_BITS-1:0]              cnt_ff;
   logic                             busy_ff, done_ff, last;

   assign last = (cnt_ff == CNT_BITS'(ssb_pkg::MUL_B - 1));

   always_comb begin
      addend = '0;
      if (lo_ff[0]) begin
         // top multiplier bit carries negative weight
         addend = last ? -{a_ff[ssb_pkg::MUL_A-1], a_ff} : {a_ff[ssb_pkg::MUL_A-1], a_ff};
      end
      sum = hi_ff + addend;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && last;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            hi_ff   <= '0;
            lo_ff   <= mplier;
            a_ff    <= mcand;
         end else if (busy_ff) begin
            hi_ff  <= {sum[ssb_pkg::MUL_A], sum[ssb_pkg::MUL_A:1]};
            lo_ff  <= {sum[0], lo_ff[ssb_pkg::MUL_B-1:1]};
            cnt_ff <= cnt_ff + 1'b1;
            if (last) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done    = done_ff;
   assign product = ssb_pkg::PROD_WIDTH'({hi_ff, lo_ff});
endmodule

@@ sv/ssb_sine_rom.sv @@
// Quarter-wave sine table with registered read, built at elaboration.
// Depends on ssb_pkg.
module ssb_sine_rom (
   input  logic                              clock,
   input  logic [ssb_pkg::SINE_ABITS-1:0]    addr,
   output ssb_pkg::sine_type                 data
);
   localparam ssb_pkg::sine_table_type ROM = ssb_pkg::build_sine_table();

   ssb_pkg::sine_type data_ff;

   always_ff @(posedge clock) begin
      data_ff <= ROM[addr];
   end

   assign data = data_ff;
endmodule

@@ sv/ssb_checker.sv @@
// Port-level checker for the SSB frequency shifter, bound to the top level.
// Depends on assert_macros.svh and ssb_pkg.
`include "assert_macros.svh"

module ssb_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input ssb_pkg::sample_type rsp_sample,
   input logic                csr_pready
);
   `SSB_ASSERT_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "rsp valid dropped while stalled")
   `SSB_ASSERT_RST(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_sample), "rsp item changed while stalled")
   `SSB_ASSERT_ALL(a_rsp_reset, clock, $past(reset) |-> !rsp_valid, "rsp valid right after reset")
   `SSB_ASSERT_RST(a_one_item, clock, reset, req_valid && req_ready |=> !req_ready, "second item taken while busy")
   `SSB_ASSERT_ALL(a_pready, clock, csr_pready, "csr pready low")
endmodule

bind ssb_frequency_shifter ssb_checker u_ssb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_chan.valid),
   .req_ready  (req_chan.ready),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_sample (rsp_chan.sample_out),
   .csr_pready (csr_pready)
);
